// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/core/ssi_pkg.sv -----
package ssi_pkg;

   localparam int CAPACITY = 32;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 2;
   localparam int POS_W    = 6;
   localparam int INDEX_W  = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } tbl_wr_type;

endpackage

// ----- rtl/core/ssi_req_if.sv -----
interface ssi_req_if
   import ssi_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic        [CMD_W-1:0]   cmd;
   logic signed [DATA_W-1:0]  value;
   logic        [INDEX_W-1:0] index;

   modport source (output valid, output cmd, output value, output index, input ready);
   modport sink (input valid, input cmd, input value, input index, output ready);
endinterface

// ----- rtl/core/ssi_rsp_if.sv -----
interface ssi_rsp_if
   import ssi_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic        [STAT_W-1:0] status;
   logic        [POS_W-1:0]  position;
   logic        [POS_W-1:0]  count;
   logic signed [DATA_W-1:0] read_value;

   modport source (output valid, output status, output position, output count,
                   output read_value, input ready);
   modport sink (input valid, input status, input position, input count,
                 input read_value, output ready);
endinterface

// ----- rtl/core/sorted_set_insert.sv -----
// Ascending set of distinct signed 32-bit values held in a single-port-write,
// registered-read table of CAPACITY entries. One beat in gives one beat out.
// Insert scans upward one entry a cycle until it meets the first entry not
// below the value, then moves the larger entries up one place, one a cycle,
// and writes the value into the gap. A duplicate answers after the scan
// alone, and so does a full table. A read waits on the registered read port;
// a read past the count, clear and unused commands answer without a table
// access. The table's one write and one read port set the pace of scan and
// shift. Once the response sits in the output register a new request is
// taken, even while that response waits.
`include "assert_macros.svh"

module sorted_set_insert
   import ssi_pkg::*;
(
   input logic        clock,
   input logic        reset,
   ssi_req_if.sink    req_chan,
   ssi_rsp_if.source  rsp_chan
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_RDWAIT = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic                     pend_ff, pend_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         ptr_ff, ptr_in;
   logic [IDX_W-1:0]         dest_ff, dest_in;
   logic [IDX_W-1:0]         ins_ff, ins_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [STAT_W-1:0]        res_status_ff, res_status_in;
   logic [POS_W-1:0]         res_pos_ff, res_pos_in;
   logic [DATA_W-1:0]        res_read_ff, res_read_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0]         rsp_count_ff, rsp_count_in;
   logic [DATA_W-1:0]        rsp_read_ff, rsp_read_in;

   tbl_wr_type               wr;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [DATA_W-1:0]        rd_data;

   logic                     rsp_free;
   logic                     hit;
   logic [CNT_W-1:0]         ptr_dec;

   ssi_table u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign ptr_dec  = ptr_ff - CNT_W'(1);
   // shared compare: scanned entry is not below the value
   assign hit      = pend_ff && !($signed(rd_data) < val_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      dest_in       = dest_ff;
      ins_in        = ins_ff;
      val_in        = val_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_read_in   = res_read_ff;
      wr            = '0;
      rd_en         = 1'b0;
      rd_addr       = ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            res_status_in = STAT_DONE;
            res_pos_in    = '0;
            res_read_in   = '0;
            if (req_chan.valid) begin
               unique case (req_chan.cmd)
                  CMD_INSERT: begin
                     val_in   = req_chan.value;
                     ptr_in   = '0;
                     pend_in  = 1'b0;
                     state_in = ST_SCAN;
                  end
                  CMD_READ: begin
                     if (32'(req_chan.index) < 32'(count_ff)) begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(req_chan.index);
                        state_in = ST_RDWAIT;
                     end else begin
                        res_status_in = STAT_RANGE;
                        state_in      = ST_DONE;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (hit && (rd_data == val_ff)) begin
               res_status_in = STAT_DUP;
               res_pos_in    = POS_W'(ptr_dec);
               state_in      = ST_DONE;
            end else if (hit || (ptr_ff == count_ff)) begin
               if (count_ff >= CNT_W'(CAPACITY)) begin
                  res_status_in = STAT_FULL;
                  state_in      = ST_DONE;
               end else begin
                  ins_in   = hit ? IDX_W'(ptr_dec) : IDX_W'(ptr_ff);
                  ptr_in   = count_ff;
                  pend_in  = 1'b0;
                  state_in = ST_SHIFT;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
         end

         ST_SHIFT: begin
            pend_in = 1'b0;
            // retire the entry fetched last cycle one place up
            if (pend_ff) begin
               wr.en   = 1'b1;
               wr.addr = dest_ff;
               wr.data = rd_data;
            end
            if (ptr_ff > CNT_W'(ins_ff)) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(ptr_dec);
               dest_in = IDX_W'(ptr_ff);
               ptr_in  = ptr_dec;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               wr.en      = 1'b1;
               wr.addr    = ins_ff;
               wr.data    = val_ff;
               count_in   = count_ff + CNT_W'(1);
               res_pos_in = POS_W'(ins_ff);
               state_in   = ST_DONE;
            end
         end

         ST_RDWAIT: begin
            res_read_in = rd_data;
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_read_in   = rsp_read_ff;
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_pos_in    = res_pos_ff;
         rsp_count_in  = POS_W'(count_ff);
         rsp_read_in   = res_read_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      dest_ff       <= dest_in;
      ins_ff        <= ins_in;
      val_ff        <= val_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_read_ff   <= res_read_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_read_ff   <= rsp_read_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.position   = rsp_pos_ff;
   assign rsp_chan.count      = rsp_count_ff;
   assign rsp_chan.read_value = rsp_read_ff;

   `ASSERT_CLK(a_count_bound, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")
   `ASSERT_CLK(a_write_in_shift, wr.en |-> (state_ff == ST_SHIFT), "table written outside shift")
   `ASSERT_CLK(a_shift_not_full, (state_ff == ST_SHIFT) |-> (count_ff < CNT_W'(CAPACITY)),
      "shift started on a full table")
   `ASSERT_CLK(a_shift_above_gap, (state_ff == ST_SHIFT && pend_ff) |-> (dest_ff > ins_ff),
      "shifted entry lands at or below the insertion point")

endmodule

// ----- rtl/core/ssi_table.sv -----
module ssi_table
   import ssi_pkg::*;
(
   input  logic              clock,
   input  tbl_wr_type        wr,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
